// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the neighbor table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define NT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define NT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NT_ASSERT(lbl, clk, rst, prop, msg)
`define NT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== hdl/nt_pkg.sv =====
// Types and constants of the neighbor table.
`timescale 1ns / 1ps
package nt_pkg;

  localparam int MAX_NODES_DEF = 16;

  localparam logic [1:0] OP_HEARTBEAT = 2'd0;
  localparam logic [1:0] OP_DELETE    = 2'd1;
  localparam logic [1:0] OP_SWEEP     = 2'd2;
  localparam logic [1:0] OP_QUERY     = 2'd3;

  localparam logic [2:0] ST_UPDATED  = 3'd0;
  localparam logic [2:0] ST_ADDED    = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_DELETED  = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_SWEPT    = 3'd5;
  localparam logic [2:0] ST_NEAREST  = 3'd6;
  localparam logic [2:0] ST_EMPTY    = 3'd7;

  localparam logic [63:0] EXPIRE_RESET = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [63:0]        node_id;
    logic [31:0]        net_addr;
    logic signed [31:0] lat;
    logic signed [31:0] lng;
    logic signed [31:0] alt;
    logic [15:0]        spd;
    logic [7:0]         batt;
    logic [15:0]        msg_index;
    logic [63:0]        now_us;
  } item_t;

  typedef struct packed {
    logic [63:0]        id;
    logic [31:0]        addr;
    logic signed [31:0] lat;
    logic signed [31:0] lng;
    logic signed [31:0] alt;
    logic [15:0]        spd;
    logic [7:0]         batt;
    logic [15:0]        msg;
    logic [63:0]        time_us;
  } rec_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [3:0]         slot;
    logic [63:0]        found_id;
    logic [31:0]        found_addr;
    logic signed [31:0] found_lat;
    logic signed [31:0] found_lng;
    logic signed [31:0] found_alt;
    logic [15:0]        found_spd;
    logic [7:0]         found_batt;
    logic [15:0]        found_msg;
    logic [63:0]        found_time;
    logic [4:0]         entry_count;
  } result_t;

endpackage

// ===== hdl/nt_if.sv =====
// Valid/ready channels for input items and results.
`timescale 1ns / 1ps
interface nt_item_if;
  logic          valid;
  logic          ready;
  nt_pkg::item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface nt_result_if;
  logic            valid;
  logic            ready;
  nt_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/neighbor_table_with_aging.sv =====
// Neighbor table top level: storage, table walk sequencer and result register.
// Each item walks every slot of the table once through a single-port memory. A heartbeat,
// delete or sweep reads and evaluates each slot in turn (S_READ, S_EVAL); a query adds S_MLAT,
// S_MLNG and S_CMP on each valid slot, since the squared distance goes through one shared
// 32x32 multiplier, used once for latitude and once for longitude.
// The block takes one item at a time and is ready again once its result is transferred.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module neighbor_table_with_aging #(
  parameter int MAX_NODES = nt_pkg::MAX_NODES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [63:0]  cfg_data,
  nt_item_if.sink      in_ch,
  nt_result_if.source  out_ch
);

  localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam logic [IW-1:0] LAST = IW'(MAX_NODES - 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_READ = 8'b0000_0010,
    S_EVAL = 8'b0000_0100,
    S_MLAT = 8'b0000_1000,
    S_MLNG = 8'b0001_0000,
    S_CMP  = 8'b0010_0000,
    S_FIN  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  state_t          state;
  logic [63:0]     expire;
  nt_pkg::item_t   q;
  logic [IW-1:0]   idx;
  logic [MAX_NODES-1:0] vld;
  logic [CW-1:0]   cnt;
  nt_pkg::rec_t    tbl [MAX_NODES];
  nt_pkg::rec_t    rd;
  nt_pkg::rec_t    best_rec;
  logic [IW-1:0]   best_idx;
  logic            best_found;
  logic [64:0]     best_dist;
  logic            match_found;
  logic [IW-1:0]   match_idx;
  logic            free_found;
  logic [IW-1:0]   free_idx;
  logic [31:0]     mag_lat;
  logic [31:0]     mag_lng;
  logic [63:0]     sq_lat;
  logic [63:0]     sq_lng;
  nt_pkg::result_t res;
  logic            res_valid;

  logic [31:0]     mul_a;
  logic [63:0]     mul_p;
  logic [32:0]     dlat;
  logic [32:0]     dlng;
  logic [64:0]     dsum;
  logic [63:0]     age;
  logic            id_hit;

  logic            mem_we;
  logic [IW-1:0]   wslot;
  nt_pkg::rec_t    wrec;
  logic [CW-1:0]   cnt_next;
  logic [MAX_NODES-1:0] vld_next;
  nt_pkg::result_t res_next;

  assign in_ch.ready  = (state == S_IDLE);
  assign out_ch.valid = res_valid;
  assign out_ch.data  = res;

  assign mul_a  = (state == S_MLAT) ? mag_lat : mag_lng;
  assign mul_p  = 64'(mul_a) * 64'(mul_a);
  assign dlat   = 33'(signed'(rd.lat)) - 33'(signed'(q.lat));
  assign dlng   = 33'(signed'(rd.lng)) - 33'(signed'(q.lng));
  assign dsum   = 65'(sq_lat) + 65'(sq_lng);
  assign age    = q.now_us - rd.time_us;
  assign id_hit = vld[idx] && (rd.id == q.node_id);

  assign wrec = '{id: q.node_id, addr: q.net_addr, lat: q.lat, lng: q.lng, alt: q.alt,
                  spd: q.spd, batt: q.batt, msg: q.msg_index, time_us: q.now_us};

  always_comb begin
    mem_we   = 1'b0;
    wslot    = match_idx;
    cnt_next = cnt;
    vld_next = vld;
    res_next = '0;
    case (q.opcode)
      nt_pkg::OP_HEARTBEAT: begin
        if (match_found) begin
          mem_we          = 1'b1;
          res_next.status = nt_pkg::ST_UPDATED;
          res_next.slot   = 4'(match_idx);
        end else if (free_found) begin
          mem_we          = 1'b1;
          wslot           = free_idx;
          cnt_next        = cnt + CW'(1);
          vld_next[free_idx] = 1'b1;
          res_next.status = nt_pkg::ST_ADDED;
          res_next.slot   = 4'(free_idx);
        end else begin
          res_next.status = nt_pkg::ST_FULL;
        end
      end
      nt_pkg::OP_DELETE: begin
        if (match_found) begin
          cnt_next            = cnt - CW'(1);
          vld_next[match_idx] = 1'b0;
          res_next.status     = nt_pkg::ST_DELETED;
          res_next.slot       = 4'(match_idx);
        end else begin
          res_next.status = nt_pkg::ST_NOTFOUND;
        end
      end
      nt_pkg::OP_SWEEP: begin
        res_next.status = nt_pkg::ST_SWEPT;
      end
      default: begin
        if (best_found) begin
          res_next.status     = nt_pkg::ST_NEAREST;
          res_next.slot       = 4'(best_idx);
          res_next.found_id   = best_rec.id;
          res_next.found_addr = best_rec.addr;
          res_next.found_lat  = best_rec.lat;
          res_next.found_lng  = best_rec.lng;
          res_next.found_alt  = best_rec.alt;
          res_next.found_spd  = best_rec.spd;
          res_next.found_batt = best_rec.batt;
          res_next.found_msg  = best_rec.msg;
          res_next.found_time = best_rec.time_us;
        end else begin
          res_next.status = nt_pkg::ST_EMPTY;
        end
      end
    endcase
    res_next.entry_count = 5'(cnt_next);
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && mem_we) begin
      tbl[wslot] <= wrec;
    end
    if (state == S_READ) begin
      rd <= tbl[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expire <= nt_pkg::EXPIRE_RESET;
    end else if (cfg_we) begin
      expire <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      vld       <= '0;
      cnt       <= '0;
      res_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            q           <= in_ch.data;
            idx         <= '0;
            match_found <= 1'b0;
            free_found  <= 1'b0;
            best_found  <= 1'b0;
            state       <= S_READ;
          end
        end
        S_READ: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (q.opcode == nt_pkg::OP_QUERY && vld[idx]) begin
            state <= S_MLAT;
          end else begin
            state <= (idx == LAST) ? S_FIN : S_READ;
            idx   <= idx + IW'(1);
          end
          case (q.opcode)
            nt_pkg::OP_HEARTBEAT, nt_pkg::OP_DELETE: begin
              if (id_hit && !match_found) begin
                match_found <= 1'b1;
                match_idx   <= idx;
              end
              if (!vld[idx] && !free_found) begin
                free_found <= 1'b1;
                free_idx   <= idx;
              end
            end
            nt_pkg::OP_SWEEP: begin
              if (vld[idx] && age >= expire) begin
                vld[idx] <= 1'b0;
                cnt      <= cnt - CW'(1);
              end
            end
            default: begin
              if (vld[idx]) begin
                mag_lat <= dlat[32] ? 32'(-dlat) : dlat[31:0];
                mag_lng <= dlng[32] ? 32'(-dlng) : dlng[31:0];
              end
            end
          endcase
        end
        S_MLAT: begin
          sq_lat <= mul_p;
          state  <= S_MLNG;
        end
        S_MLNG: begin
          sq_lng <= mul_p;
          state  <= S_CMP;
        end
        S_CMP: begin
          if (!best_found || dsum <= best_dist) begin
            best_found <= 1'b1;
            best_dist  <= dsum;
            best_idx   <= idx;
            best_rec   <= rd;
          end
          state <= (idx == LAST) ? S_FIN : S_READ;
          idx   <= idx + IW'(1);
        end
        S_FIN: begin
          vld       <= vld_next;
          cnt       <= cnt_next;
          res       <= res_next;
          res_valid <= 1'b1;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (out_ch.ready) begin
            res_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `NT_ASSERT(a_cnt_range, clk, rst, cnt <= CW'(MAX_NODES), "entry count above table size")
  `NT_ASSERT(a_busy_excl, clk, rst, !(in_ch.ready && out_ch.valid), "ready while result held")
  `NT_ASSERT(a_out_from_fin, clk, rst, $rose(res_valid) |-> $past(state) == S_FIN, "stray result")
  `NT_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> state == S_IDLE && !res_valid, "reset not idle")

endmodule
